/* hw/rtl/ffha_pkg.sv */
// Shared types and codes for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dpath and first_fit_heap_allocator_unit; no dependencies.
`default_nettype none

package ffha_pkg;

  localparam int REQ_W = 16;
  localparam int CFG_W = 17;

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFIT  = 2'd1;
  localparam logic [1:0] STAT_BADOFF = 2'd2;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_READ,
    OP_STEP,
    OP_AGRANT,
    OP_SH_RD,
    OP_SH_WR,
    OP_SPLIT_A,
    OP_SPLIT_B,
    OP_FGRANT,
    OP_RD_NEXT,
    OP_CAP_NEXT,
    OP_MERGE,
    OP_RM_RD,
    OP_RM_WR,
    OP_RM_END,
    OP_ERR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic init_pend;
    logic is_free;
    logic zero_req;
    logic walk_end;
    logic fits;
    logic split_ok;
    logic hit;
    logic in_use;
    logic has_next;
    logic sh_more;
    logic rm_more;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/ffha_dpath.sv */
// Datapath of the heap allocator: block table memory, walk counters, result registers.
// Depends on ffha_pkg; driven by ffha_ctrl commands.
`default_nettype none

module ffha_dpath #(
  parameter int MAX_BLOCKS   = 64,
  parameter int ARENA_MAX    = 65536,
  parameter int HEADER_BYTES = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ffha_pkg::cmd_t              cmd,
  output ffha_pkg::stat_t                  stat,
  input  wire logic                        cfg_we,
  input  wire logic [ffha_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                        in_kind,
  input  wire logic [ffha_pkg::REQ_W-1:0]  in_size,
  input  wire logic [ffha_pkg::REQ_W-1:0]  in_offset,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [ffha_pkg::REQ_W-1:0]       out_offset,
  output logic [ffha_pkg::REQ_W-1:0]       out_size
);

  localparam int LW0 = $clog2(ARENA_MAX + 1);
  localparam int LW  = (LW0 > ffha_pkg::CFG_W) ? LW0 : ffha_pkg::CFG_W;
  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int ARENA_RST = (ARENA_MAX < 65536) ? ARENA_MAX : 65536;
  localparam logic [LW-1:0] HDR  = LW'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

  // Table entry: in-use flag above the payload length.
  logic [LW:0]   blk_mem_r [MAX_BLOCKS];
  logic [LW:0]   rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [LW:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  logic [LW-1:0] arena_r;
  logic          init_pend_r;
  logic          kind_r;
  logic [ffha_pkg::REQ_W-1:0] size_r, rel_r;
  logic [CW-1:0] k_r, total_r, i_r;
  logic [1:0]    d_r;
  logic [LW-1:0] pos_r, prev_len_r, cur_len_r, next_len_r;
  logic          prev_use_r, nf_r;
  logic [1:0]    res_status_r;
  logic [ffha_pkg::REQ_W-1:0] res_off_r, res_size_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [ffha_pkg::REQ_W-1:0] out_off_r, out_size_r;

  logic [LW-1:0] rd_len, size_ext, rel_ext, hdr_pos;
  logic          rd_use, pf;
  logic [CW-1:0] k_p1, k_m1;
  logic [CW:0]   i_pd;
  logic [31:0]   cfg_ext;
  logic [LW-1:0] cfg_clamped;

  assign rd_len   = rd_r[LW-1:0];
  assign rd_use   = rd_r[LW];
  assign size_ext = LW'(size_r);
  assign rel_ext  = LW'(rel_r);
  assign hdr_pos  = pos_r + HDR;
  assign k_p1     = k_r + CW'(1);
  assign k_m1     = k_r - CW'(1);
  assign i_pd     = (CW+1)'(i_r) + (CW+1)'(d_r);
  assign pf       = (k_r != '0) && !prev_use_r;

  assign cfg_ext = 32'(cfg_wdata);
  always_comb begin
    if (cfg_ext < 32'(HEADER_BYTES + 1)) begin
      cfg_clamped = LW'(HEADER_BYTES + 1);
    end else if (cfg_ext > 32'(ARENA_MAX)) begin
      cfg_clamped = LW'(ARENA_MAX);
    end else begin
      cfg_clamped = cfg_ext[LW-1:0];
    end
  end

  always_comb begin
    stat.init_pend = init_pend_r;
    stat.is_free   = (kind_r == ffha_pkg::KIND_FREE);
    stat.zero_req  = (size_r == '0);
    stat.walk_end  = (k_r >= total_r);
    stat.fits      = !rd_use && (rd_len >= size_ext);
    stat.split_ok  = (rd_len > size_ext + HDR) && (total_r < MAXB);
    stat.hit       = (hdr_pos == rel_ext);
    stat.in_use    = rd_use;
    stat.has_next  = (k_p1 < total_r);
    stat.sh_more   = (i_r > k_p1);
    stat.rm_more   = (d_r != 2'd0) && (i_pd < (CW+1)'(total_r));
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Memory port steering.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    case (cmd.op)
      ffha_pkg::OP_INIT: begin
        mem_we = 1'b1;
        mem_wd = {1'b0, arena_r - HDR};
      end
      ffha_pkg::OP_READ: begin
        mem_re = 1'b1;
        mem_ra = k_r[AW-1:0];
      end
      ffha_pkg::OP_AGRANT: begin
        mem_we = !stat.split_ok;
        mem_wa = k_r[AW-1:0];
        mem_wd = {1'b1, rd_len};
      end
      ffha_pkg::OP_SH_RD: begin
        mem_re = 1'b1;
        mem_ra = AW'(i_r - CW'(1));
      end
      ffha_pkg::OP_SH_WR: begin
        mem_we = 1'b1;
        mem_wa = i_r[AW-1:0];
        mem_wd = rd_r;
      end
      ffha_pkg::OP_SPLIT_A: begin
        mem_we = 1'b1;
        mem_wa = k_p1[AW-1:0];
        mem_wd = {1'b0, cur_len_r - size_ext - HDR};
      end
      ffha_pkg::OP_SPLIT_B: begin
        mem_we = 1'b1;
        mem_wa = k_r[AW-1:0];
        mem_wd = {1'b1, size_ext};
      end
      ffha_pkg::OP_RD_NEXT: begin
        mem_re = 1'b1;
        mem_ra = k_p1[AW-1:0];
      end
      ffha_pkg::OP_MERGE: begin
        mem_we = 1'b1;
        case ({pf, nf_r})
          2'b01: begin
            mem_wa = k_r[AW-1:0];
            mem_wd = {1'b0, cur_len_r + HDR + next_len_r};
          end
          2'b10: begin
            mem_wa = k_m1[AW-1:0];
            mem_wd = {1'b0, prev_len_r + HDR + cur_len_r};
          end
          2'b11: begin
            mem_wa = k_m1[AW-1:0];
            mem_wd = {1'b0, prev_len_r + HDR + cur_len_r + HDR + next_len_r};
          end
          default: begin
            mem_wa = k_r[AW-1:0];
            mem_wd = {1'b0, cur_len_r};
          end
        endcase
      end
      ffha_pkg::OP_RM_RD: begin
        mem_re = 1'b1;
        mem_ra = i_pd[AW-1:0];
      end
      ffha_pkg::OP_RM_WR: begin
        mem_we = 1'b1;
        mem_wa = i_r[AW-1:0];
        mem_wd = rd_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= blk_mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r     <= LW'(ARENA_RST);
      init_pend_r <= 1'b1;
      total_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        arena_r     <= cfg_clamped;
        init_pend_r <= 1'b1;
      end else if (cmd.op == ffha_pkg::OP_INIT) begin
        init_pend_r <= 1'b0;
      end
      if (cmd.op == ffha_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        ffha_pkg::OP_INIT:    total_r <= CW'(1);
        ffha_pkg::OP_SPLIT_B: total_r <= total_r + CW'(1);
        ffha_pkg::OP_RM_END:  total_r <= total_r - CW'(d_r);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ffha_pkg::OP_LOAD: begin
        kind_r <= in_kind;
        size_r <= in_size;
        rel_r  <= in_offset;
        k_r    <= '0;
        pos_r  <= '0;
        d_r    <= 2'd0;
      end
      ffha_pkg::OP_STEP: begin
        prev_len_r <= rd_len;
        prev_use_r <= rd_use;
        pos_r      <= hdr_pos + rd_len;
        k_r        <= k_p1;
      end
      ffha_pkg::OP_AGRANT: begin
        res_status_r <= ffha_pkg::STAT_OK;
        res_off_r    <= hdr_pos[ffha_pkg::REQ_W-1:0];
        cur_len_r    <= rd_len;
        i_r          <= total_r;
        res_size_r   <= stat.split_ok ? size_r : rd_len[ffha_pkg::REQ_W-1:0];
      end
      ffha_pkg::OP_SH_WR: i_r <= i_r - CW'(1);
      ffha_pkg::OP_FGRANT: begin
        res_status_r <= ffha_pkg::STAT_OK;
        res_off_r    <= rel_r;
        res_size_r   <= rd_len[ffha_pkg::REQ_W-1:0];
        cur_len_r    <= rd_len;
        nf_r         <= 1'b0;
      end
      ffha_pkg::OP_CAP_NEXT: begin
        nf_r       <= !rd_use;
        next_len_r <= rd_len;
      end
      ffha_pkg::OP_MERGE: begin
        case ({pf, nf_r})
          2'b01: begin
            i_r <= k_p1;
            d_r <= 2'd1;
          end
          2'b10: begin
            i_r <= k_r;
            d_r <= 2'd1;
          end
          2'b11: begin
            i_r <= k_r;
            d_r <= 2'd2;
          end
          default: d_r <= 2'd0;
        endcase
      end
      ffha_pkg::OP_RM_WR: i_r <= i_r + CW'(1);
      ffha_pkg::OP_ERR: begin
        res_status_r <= (kind_r == ffha_pkg::KIND_FREE) ? ffha_pkg::STAT_BADOFF
                                                        : ffha_pkg::STAT_NOFIT;
        res_off_r    <= '0;
        res_size_r   <= '0;
      end
      ffha_pkg::OP_EMIT: begin
        out_status_r <= res_status_r;
        out_off_r    <= res_off_r;
        out_size_r   <= res_size_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_offset = out_off_r;
  assign out_size   = out_size_r;

endmodule

`default_nettype wire

/* hw/rtl/ffha_ctrl.sv */
// Sequencing state machine of the heap allocator: walk, split shift, merge shift.
// Depends on ffha_pkg; commands ffha_dpath.
`default_nettype none

module ffha_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t       cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DISP  = 14'b00000000000010,
    S_RD    = 14'b00000000000100,
    S_EV    = 14'b00000000001000,
    S_SHC   = 14'b00000000010000,
    S_SHW   = 14'b00000000100000,
    S_SPB   = 14'b00000001000000,
    S_NRD   = 14'b00000010000000,
    S_NCAP  = 14'b00000100000000,
    S_MERGE = 14'b00001000000000,
    S_RMC   = 14'b00010000000000,
    S_RMW   = 14'b00100000000000,
    S_ERR   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !stat.init_pend;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ffha_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (stat.init_pend) begin
          cmd.op = ffha_pkg::OP_INIT;
        end else if (in_valid) begin
          cmd.op    = ffha_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = (!stat.is_free && stat.zero_req) ? S_ERR : S_RD;
      end
      S_RD: begin
        if (stat.walk_end) begin
          state_nxt = S_ERR;
        end else begin
          cmd.op    = ffha_pkg::OP_READ;
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        if (!stat.is_free) begin
          if (stat.fits) begin
            cmd.op    = ffha_pkg::OP_AGRANT;
            state_nxt = stat.split_ok ? S_SHC : S_DONE;
          end else begin
            cmd.op    = ffha_pkg::OP_STEP;
            state_nxt = S_RD;
          end
        end else if (stat.hit) begin
          if (stat.in_use) begin
            cmd.op    = ffha_pkg::OP_FGRANT;
            state_nxt = stat.has_next ? S_NRD : S_MERGE;
          end else begin
            state_nxt = S_ERR;
          end
        end else begin
          cmd.op    = ffha_pkg::OP_STEP;
          state_nxt = S_RD;
        end
      end
      S_SHC: begin
        if (stat.sh_more) begin
          cmd.op    = ffha_pkg::OP_SH_RD;
          state_nxt = S_SHW;
        end else begin
          cmd.op    = ffha_pkg::OP_SPLIT_A;
          state_nxt = S_SPB;
        end
      end
      S_SHW: begin
        cmd.op    = ffha_pkg::OP_SH_WR;
        state_nxt = S_SHC;
      end
      S_SPB: begin
        cmd.op    = ffha_pkg::OP_SPLIT_B;
        state_nxt = S_DONE;
      end
      S_NRD: begin
        cmd.op    = ffha_pkg::OP_RD_NEXT;
        state_nxt = S_NCAP;
      end
      S_NCAP: begin
        cmd.op    = ffha_pkg::OP_CAP_NEXT;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.op    = ffha_pkg::OP_MERGE;
        state_nxt = S_RMC;
      end
      S_RMC: begin
        if (stat.rm_more) begin
          cmd.op    = ffha_pkg::OP_RM_RD;
          state_nxt = S_RMW;
        end else begin
          cmd.op    = ffha_pkg::OP_RM_END;
          state_nxt = S_DONE;
        end
      end
      S_RMW: begin
        cmd.op    = ffha_pkg::OP_RM_WR;
        state_nxt = S_RMC;
      end
      S_ERR: begin
        cmd.op    = ffha_pkg::OP_ERR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = ffha_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/first_fit_heap_allocator_unit.sv */
// Top level of the first-fit heap allocator: stream ports, controller and datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_dpath.
`default_nettype none

// First-fit heap allocator with coalescing. The arena is kept as an
// address-ordered table of up to MAX_BLOCKS blocks, each a HEADER_BYTES header
// plus payload, held in a single-port-write, registered-read memory. An
// allocate beat (tuser 0) walks the table from the start and takes the first
// free block big enough; a block larger than request plus one header is split
// when the table has room, else granted whole. A free beat (tuser 1) finds the
// block whose payload starts at the given offset, releases it and merges it with
// free neighbors on both sides. Each input beat yields exactly one result beat:
// status 0 ok, 1 no fit (also a zero request), 2 bad free offset; offset and
// size read 0 on error. One item is processed at a time. Each table entry
// walked costs one memory read and one evaluate; each entry moved when a split
// opens a slot or a merge closes one costs a read and a write; on top come the
// load, dispatch, the split or merge steps and the emit. The walk and the shift
// never cover the same entry twice. The memory port is the limit. A finished
// result waits in the output register while the next beat is taken. After
// reset and after every cfg_we write, the table is rebuilt as a single free
// block before input is accepted again; write the arena size only while the
// block is idle.
module first_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS   = 64,
  parameter int ARENA_MAX    = 65536,
  parameter int HEADER_BYTES = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: arena size in bytes
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  // Requests
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] request_size, [31:16] release_offset
  input  wire logic        in_tuser,   // [0] kind
  // Results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] payload_offset, [31:16] granted_size
  output logic [1:0]       out_tuser   // [1:0] status
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;
  logic [15:0]     res_off, res_size;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dpath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .ARENA_MAX    (ARENA_MAX),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_tuser),
    .in_size    (in_tdata[15:0]),
    .in_offset  (in_tdata[31:16]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_offset (res_off),
    .out_size   (res_size)
  );

  assign out_tdata = {res_size, res_off};

  // Hold off input in the cycle after a size write while the table rebuilds.
  a_cfg_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input accepted right after arena size write");

  // Drop ready after a taken beat: one item in flight.
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in flight");

  // Error results carry no offset or size.
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ffha_pkg::STAT_OK) |-> (out_tdata == 32'd0))
    else $error("error result with nonzero payload");

  // A granted or released payload always sits past the first header.
  a_ok_offset : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ffha_pkg::STAT_OK) |->
      (32'(out_tdata[15:0]) >= 32'(HEADER_BYTES)))
    else $error("ok result offset inside first header");

endmodule

`default_nettype wire
